### design/md5bc_pkg.sv
// Shared constants, tables and helpers for the MD5 block compression core.
package md5bc_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned Rounds  = 64;
  localparam int unsigned BufWords = 16;

  typedef logic [WordW-1:0] word_t;
  typedef logic [5:0]       round_t;
  typedef logic [3:0]       widx_t;
  typedef logic [4:0]       rot_t;

  // Standard initial chaining value
  localparam word_t InitA = 32'h67452301;
  localparam word_t InitB = 32'hefcdab89;
  localparam word_t InitC = 32'h98badcfe;
  localparam word_t InitD = 32'h10325476;

  // Round group codes
  localparam logic [1:0] GrpF = 2'd0;
  localparam logic [1:0] GrpG = 2'd1;
  localparam logic [1:0] GrpH = 2'd2;
  localparam logic [1:0] GrpI = 2'd3;

  // Additive constant for each round
  function automatic word_t round_k(input round_t r);
    word_t k;
    case (r)
      6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
      6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
      6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
      6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
      6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
      6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
      6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
      6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
      6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
      6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
      6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
      6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
      6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
      6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
      6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
      6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
      6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
      6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
      6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
      6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
      6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
      6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
      6'd62: k = 32'h2ad7d2bb;  default: k = 32'heb86d391;
    endcase
    return k;
  endfunction

  // Left-rotate amount, four per round group
  function automatic rot_t round_rot(input round_t r);
    rot_t s;
    case ({r[5:4], r[1:0]})
      4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
      4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
      4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
      4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  default: s = 5'd21;
    endcase
    return s;
  endfunction

  // Message word schedule: index into the block buffer, mod 16
  function automatic widx_t round_widx(input round_t r);
    widx_t lo;
    widx_t idx;
    lo = r[3:0];
    case (r[5:4])
      GrpF:    idx = lo;
      GrpG:    idx = widx_t'({lo, 2'b00} + lo + 4'd1);
      GrpH:    idx = widx_t'({lo, 1'b0} + lo + 4'd5);
      default: idx = widx_t'({lo, 3'b000} - lo);
    endcase
    return idx;
  endfunction

endpackage

### design/md5_block_compress.sv
// Top level of the MD5 block compression core: word buffer, round sequencer, chaining value.
//
// Each transfer on start/busy brings one 32-bit little-endian message word; the host has
// already padded the message. Words 0 to 14 of a block are taken one per cycle. After the
// 16th word busy rises while a single shared round unit runs the 64 MD5 steps, one per
// cycle, then the fold state adds the result of the 512-bit block into the chaining value.
// done is high for exactly one cycle with the new chaining value on hash_a to hash_d; the
// receiver cannot hold it off, and the values stay on the ports until the next block
// completes or a first word with new_message reloads the initial value, which then shows
// on the ports from the following cycle. new_message on a block's first word reloads the
// standard initial value.
module md5_block_compress (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  md5bc_pkg::word_t     msg_word,
  input  logic                 new_message,
  output logic                 done,
  output md5bc_pkg::word_t     hash_a,
  output md5bc_pkg::word_t     hash_b,
  output md5bc_pkg::word_t     hash_c,
  output md5bc_pkg::word_t     hash_d
);

  typedef enum logic [1:0] {
    S_LOAD,
    S_RUN,
    S_FOLD
  } state_t;

  state_t            state;
  md5bc_pkg::widx_t  word_count;
  md5bc_pkg::round_t rnd;
  md5bc_pkg::word_t  block_buf [md5bc_pkg::BufWords];
  md5bc_pkg::word_t  chain [4];
  md5bc_pkg::word_t  a, b, c, d;
  md5bc_pkg::word_t  b_new;
  md5bc_pkg::word_t  m_word;
  logic              accept;
  logic              reload;

  assign accept = start && (state == S_LOAD);
  assign reload = accept && (word_count == '0) && new_message;
  assign busy   = (state != S_LOAD);
  assign m_word = block_buf[md5bc_pkg::round_widx(rnd)];

  assign hash_a = chain[0];
  assign hash_b = chain[1];
  assign hash_c = chain[2];
  assign hash_d = chain[3];

  md5bc_round u_round (
    .a     (a),
    .b     (b),
    .c     (c),
    .d     (d),
    .m     (m_word),
    .rnd   (rnd),
    .b_new (b_new)
  );

  // Store each transferred word in the block buffer
  always_ff @(posedge clk) begin
    if (accept) begin
      block_buf[word_count] <= msg_word;
    end
  end

  // Sequencer, working registers and chaining value
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_LOAD;
      word_count <= '0;
      rnd        <= '0;
      done       <= 1'b0;
      chain[0]   <= md5bc_pkg::InitA;
      chain[1]   <= md5bc_pkg::InitB;
      chain[2]   <= md5bc_pkg::InitC;
      chain[3]   <= md5bc_pkg::InitD;
    end else begin
      done <= (state == S_FOLD);
      case (state)
        S_LOAD: begin
          if (accept) begin
            word_count <= word_count + 4'd1;
            if (reload) begin
              chain[0] <= md5bc_pkg::InitA;
              chain[1] <= md5bc_pkg::InitB;
              chain[2] <= md5bc_pkg::InitC;
              chain[3] <= md5bc_pkg::InitD;
            end
            // Last word of the block: start the rounds
            if (word_count == 4'd15) begin
              state <= S_RUN;
              rnd   <= '0;
            end
          end
        end
        S_RUN: begin
          rnd <= rnd + 6'd1;
          if (rnd == 6'(md5bc_pkg::Rounds - 1)) begin
            state <= S_FOLD;
          end
        end
        S_FOLD: begin
          chain[0] <= chain[0] + a;
          chain[1] <= chain[1] + b;
          chain[2] <= chain[2] + c;
          chain[3] <= chain[3] + d;
          state    <= S_LOAD;
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

  // Working variables: load from the chaining value, then rotate through the rounds
  always_ff @(posedge clk) begin
    if (state == S_LOAD) begin
      if (reload) begin
        a <= md5bc_pkg::InitA;
        b <= md5bc_pkg::InitB;
        c <= md5bc_pkg::InitC;
        d <= md5bc_pkg::InitD;
      end else begin
        a <= chain[0];
        b <= chain[1];
        c <= chain[2];
        d <= chain[3];
      end
    end else if (state == S_RUN) begin
      a <= d;
      b <= b_new;
      c <= b;
      d <= c;
    end
  end

endmodule

### design/md5bc_round.sv
// One MD5 step: round function, constant and message add, rotate, add to B.
module md5bc_round (
  input  md5bc_pkg::word_t  a,
  input  md5bc_pkg::word_t  b,
  input  md5bc_pkg::word_t  c,
  input  md5bc_pkg::word_t  d,
  input  md5bc_pkg::word_t  m,
  input  md5bc_pkg::round_t rnd,
  output md5bc_pkg::word_t  b_new
);

  md5bc_pkg::word_t f;
  md5bc_pkg::word_t sum;
  md5bc_pkg::word_t rot;
  md5bc_pkg::rot_t  sh;

  // Select the boolean function for this round group
  always_comb begin
    case (rnd[5:4])
      md5bc_pkg::GrpF: f = (b & c) | (~b & d);
      md5bc_pkg::GrpG: f = (d & b) | (~d & c);
      md5bc_pkg::GrpH: f = b ^ c ^ d;
      default:         f = c ^ (b | ~d);
    endcase
  end

  // Sum, rotate left, add B
  always_comb begin
    sh    = md5bc_pkg::round_rot(rnd);
    sum   = a + f + md5bc_pkg::round_k(rnd) + m;
    rot   = (sum << sh) | (sum >> (6'd32 - {1'b0, sh}));
    b_new = b + rot;
  end

endmodule

### design/md5bc_checker.sv
// Port-level checks for the MD5 block compression core, bound to the top level.
module md5bc_checker (
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input logic             done,
  input md5bc_pkg::word_t hash_a,
  input md5bc_pkg::word_t hash_b,
  input md5bc_pkg::word_t hash_c,
  input md5bc_pkg::word_t hash_d
);

  // The core only goes busy after a transfer
  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("busy rose without a transfer");

  // A result only follows a busy period and comes with the core free again
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(busy) && !busy))
    else $error("done without a preceding compression");

  // A result is a single-cycle strobe
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done held for more than one cycle");

  // The chaining value holds while a compression runs
  a_hash_hold: assert property (@(posedge clk) disable iff (rst)
    (busy && $past(busy)) |->
      ($stable(hash_a) && $stable(hash_b) && $stable(hash_c) && $stable(hash_d)))
    else $error("hash outputs moved during compression");

endmodule

bind md5_block_compress md5bc_checker u_md5bc_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .hash_a (hash_a),
  .hash_b (hash_b),
  .hash_c (hash_c),
  .hash_d (hash_d)
);
